@@ hdl/gbf_pkg.sv @@
package gbf_pkg;

    localparam int unsigned TABLE_WORDS_DEF = 1024;
    localparam int unsigned WORDS_W         = 11;
    localparam int unsigned SHIFT_W         = 3;
    localparam int unsigned HASH_W          = 32;
    localparam int unsigned INDEX_W         = 10;
    localparam int unsigned WORD_BITS       = 64;
    localparam int unsigned BIT_SEL_W       = 6;
    localparam int unsigned DIVIDEND_W      = HASH_W - BIT_SEL_W;
    localparam int unsigned STEP_W          = 5;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned QUEUE_PTR_W     = 2;

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

    localparam logic CFG_BLOOM_WORDS = 1'b0;
    localparam logic CFG_BLOOM_SHIFT = 1'b1;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TEST = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] name_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic              may_exist;
        logic [HASH_W-1:0] name_hash;
        logic [INDEX_W-1:0] word_index;
    } result_item_t;

    typedef struct packed {
        logic              mode;
        logic [HASH_W-1:0] hash;
    } job_t;

endpackage

@@ hdl/gbf_front.sv @@
module gbf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  gbf_pkg::byte_item_t byte_data,
    input  logic                clearing,
    input  logic                q_full,
    output logic                q_push,
    output gbf_pkg::job_t       q_job
);

    logic [gbf_pkg::HASH_W-1:0] acc_reg;
    logic [gbf_pkg::HASH_W-1:0] acc_next;
    logic [gbf_pkg::HASH_W-1:0] hash;
    logic                       accept;

    assign byte_stall = clearing || q_full;
    assign accept     = byte_valid && !byte_stall;

    // h * 33 + byte
    assign hash = (acc_reg << 5) + acc_reg
                + {{(gbf_pkg::HASH_W-8){1'b0}}, byte_data.name_byte};

    assign q_push     = accept && byte_data.last_byte;
    assign q_job.mode = byte_data.mode;
    assign q_job.hash = hash;

    always_comb
    begin
        acc_next = acc_reg;
        if (accept)
        begin
            acc_next = byte_data.last_byte ? gbf_pkg::HASH_SEED : hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= gbf_pkg::HASH_SEED;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

@@ hdl/gbf_queue.sv @@
module gbf_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbf_pkg::job_t push_job,
    input  logic          pop,
    output gbf_pkg::job_t pop_job,
    output logic          full,
    output logic          empty
);

    gbf_pkg::job_t                     slot_reg [gbf_pkg::QUEUE_DEPTH];
    logic [gbf_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [gbf_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [gbf_pkg::QUEUE_PTR_W:0]     count_reg;
    logic [gbf_pkg::QUEUE_PTR_W:0]     count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full    = (count_reg == (gbf_pkg::QUEUE_PTR_W+1)'(gbf_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/gbf_back.sv @@
module gbf_back
#(
    parameter int unsigned TABLE_WORDS = gbf_pkg::TABLE_WORDS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gbf_pkg::WORDS_W-1:0]   cfg_words,
    input  logic [gbf_pkg::SHIFT_W-1:0]   cfg_shift,
    input  logic                          q_empty,
    input  gbf_pkg::job_t                 q_job,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          result_valid,
    input  logic                          result_stall,
    output gbf_pkg::result_item_t         result_data
);

    localparam int unsigned IDX_W = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_UPD,
        S_OUT
    } state_t;

    state_t                              state_reg;
    logic [IDX_W-1:0]                    clr_cnt_reg;
    gbf_pkg::job_t                       job_reg;
    logic [gbf_pkg::WORDS_W-1:0]         ew_reg;
    logic [gbf_pkg::DIVIDEND_W-1:0]      div_reg;
    logic [gbf_pkg::WORDS_W-1:0]         rem_reg;
    logic [gbf_pkg::STEP_W-1:0]          step_reg;
    logic                                hit_reg;
    logic                                out_valid_reg;
    gbf_pkg::result_item_t               out_data_reg;
    logic [gbf_pkg::WORD_BITS-1:0]       rd_reg;

    logic [gbf_pkg::WORD_BITS-1:0]       mem [TABLE_WORDS];

    logic [gbf_pkg::WORDS_W-1:0]         ew;
    logic [gbf_pkg::WORDS_W:0]           trial;
    logic [gbf_pkg::WORDS_W:0]           trial_sub;
    logic [gbf_pkg::WORDS_W-1:0]         rem_step;
    logic [31:0]                         rem_ext;
    logic [IDX_W-1:0]                    addr;
    logic [gbf_pkg::HASH_W-1:0]          h2;
    logic [gbf_pkg::WORD_BITS-1:0]       mask;
    logic                                hit;
    logic                                out_free;
    logic                                mem_we;
    logic [IDX_W-1:0]                    mem_waddr;
    logic [gbf_pkg::WORD_BITS-1:0]       mem_wdata;

    assign ew = ({21'b0, cfg_words} > 32'(TABLE_WORDS))
              ? gbf_pkg::WORDS_W'(TABLE_WORDS) : cfg_words;

    // restoring division, one quotient bit per cycle
    assign trial     = {rem_reg, div_reg[gbf_pkg::DIVIDEND_W-1]};
    assign trial_sub = trial - {1'b0, ew_reg};
    assign rem_step  = (trial >= {1'b0, ew_reg}) ? trial_sub[gbf_pkg::WORDS_W-1:0]
                                                 : trial[gbf_pkg::WORDS_W-1:0];

    assign rem_ext = {{(32-gbf_pkg::WORDS_W){1'b0}}, rem_reg};
    assign addr    = rem_ext[IDX_W-1:0];

    assign h2   = job_reg.hash >> cfg_shift;
    assign mask = ({{(gbf_pkg::WORD_BITS-1){1'b0}}, 1'b1}
                   << job_reg.hash[gbf_pkg::BIT_SEL_W-1:0])
                | ({{(gbf_pkg::WORD_BITS-1){1'b0}}, 1'b1}
                   << h2[gbf_pkg::BIT_SEL_W-1:0]);
    assign hit  = ((rd_reg & mask) == mask);

    assign out_free     = !out_valid_reg || !result_stall;
    assign q_pop        = (state_reg == S_IDLE) && !q_empty;
    assign clearing     = (state_reg == S_CLEAR);
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    assign mem_we    = (state_reg == S_CLEAR)
                    || ((state_reg == S_UPD) && (job_reg.mode == gbf_pkg::MODE_ADD));
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : addr;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : (rd_reg | mask);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            job_reg       <= '0;
            ew_reg        <= '0;
            div_reg       <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !result_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IDX_W'(TABLE_WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg  <= q_job;
                        ew_reg   <= ew;
                        div_reg  <= q_job.hash[gbf_pkg::HASH_W-1:gbf_pkg::BIT_SEL_W];
                        rem_reg  <= '0;
                        step_reg <= '0;
                        hit_reg  <= 1'b0;
                        state_reg <= (ew == '0) ? S_OUT : S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= rem_step;
                    div_reg  <= div_reg << 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == gbf_pkg::STEP_W'(gbf_pkg::DIVIDEND_W - 1))
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    hit_reg   <= (job_reg.mode == gbf_pkg::MODE_TEST) && hit;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_data_reg.may_exist  <= hit_reg;
                        out_data_reg.name_hash  <= job_reg.hash;
                        out_data_reg.word_index <= rem_reg[gbf_pkg::INDEX_W-1:0];
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/gnu_hash_bloom_filter.sv @@
// Bytes: one transfer per cycle while the name queue has room and no clear runs.
// Names: one at a time through the back end (pop, word-index divider, table
// read, update, output), held by result stalls; pop then output when bloom_words is 0.
// Results: result_valid is registered, set as the back end leaves its output state.
// Reset: async, active low; then the table is cleared word by word with
// byte_stall high (configuration writes still taken).
module gnu_hash_bloom_filter
#(
    parameter int unsigned TABLE_WORDS = gbf_pkg::TABLE_WORDS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  gbf_pkg::byte_item_t           byte_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output gbf_pkg::result_item_t         result_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [gbf_pkg::WORDS_W-1:0]   cfg_data
);

    logic [gbf_pkg::WORDS_W-1:0] words_reg;
    logic [gbf_pkg::SHIFT_W-1:0] shift_reg;
    logic                        clearing;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_push;
    logic                        q_pop;
    gbf_pkg::job_t               push_job;
    gbf_pkg::job_t               pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg <= '0;
            shift_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gbf_pkg::CFG_BLOOM_WORDS: words_reg <= cfg_data;
                gbf_pkg::CFG_BLOOM_SHIFT: shift_reg <= cfg_data[gbf_pkg::SHIFT_W-1:0];
                default:                  words_reg <= words_reg;
            endcase
        end
    end

    gbf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .clearing   (clearing),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    gbf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    gbf_back
    #(
        .TABLE_WORDS (TABLE_WORDS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_words    (words_reg),
        .cfg_shift    (shift_reg),
        .q_empty      (q_empty),
        .q_job        (pop_job),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

@@ tb/gnu_hash_bloom_filter_test.sv @@
`timescale 1ns / 100ps

module gnu_hash_bloom_filter_test;

    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned NAME_SLOTS    = 64;
    localparam int unsigned NAME_MAX      = 12;
    localparam int unsigned PHASE_BYTES   = 180;
    localparam int unsigned PHASES        = 9;

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          byte_valid   = 1'b0;
    logic                          byte_stall;
    gbf_pkg::byte_item_t           byte_data    = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    gbf_pkg::result_item_t         result_data;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_index    = gbf_pkg::CFG_BLOOM_WORDS;
    logic [gbf_pkg::WORDS_W-1:0]   cfg_data     = '0;

    gbf_pkg::byte_item_t           pending_bytes[$];
    gbf_pkg::result_item_t         expected_results[$];

    // filter model
    logic [gbf_pkg::HASH_W-1:0]    running_hash = gbf_pkg::HASH_SEED;
    logic [63:0]                   filter_words [0:gbf_pkg::TABLE_WORDS_DEF-1]
                                       = '{default: '0};
    logic [gbf_pkg::WORDS_W-1:0]   words_in_use = '0;
    logic [gbf_pkg::SHIFT_W-1:0]   second_shift = '0;

    // names kept for re-adding and re-testing
    logic [7:0]           known_names [0:NAME_SLOTS-1][0:NAME_MAX-1];
    int unsigned          known_len [0:NAME_SLOTS-1];
    int unsigned          known_count = 0;
    logic [7:0]           draft [0:NAME_MAX-1];

    int unsigned          sender_idle_pct = 0;
    int unsigned          recv_stall_pct  = 0;
    int unsigned          mismatch_count  = 0;
    int unsigned          bytes_sent      = 0;
    int unsigned          names_checked   = 0;
    int unsigned          filter_hits     = 0;
    int unsigned          settings_used   = 1;

    gnu_hash_bloom_filter DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endtask

    function automatic void hash_byte(input gbf_pkg::byte_item_t item);
        logic [gbf_pkg::HASH_W-1:0]  h;
        logic [gbf_pkg::HASH_W-1:0]  h2;
        logic [63:0]                 mask;
        int unsigned                 used;
        int unsigned                 n;
        gbf_pkg::result_item_t       res;
        h = running_hash * 33 + item.name_byte;
        if (!item.last_byte)
        begin
            running_hash = h;
            return;
        end
        running_hash = gbf_pkg::HASH_SEED;
        used = (words_in_use > gbf_pkg::TABLE_WORDS_DEF) ? gbf_pkg::TABLE_WORDS_DEF
                                                          : words_in_use;
        n = 0;
        res = '0;
        if (used != 0)
        begin
            h2 = h >> second_shift;
            mask = (64'd1 << h[5:0]) | (64'd1 << h2[5:0]);
            n = (h >> 6) % used;
            if (item.mode == gbf_pkg::MODE_ADD)
                filter_words[n] = filter_words[n] | mask;
            else
                res.may_exist = ((filter_words[n] & mask) == mask);
        end
        res.name_hash = h;
        res.word_index = n[gbf_pkg::INDEX_W-1:0];
        expected_results = {expected_results, res};
    endfunction

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data  <= '0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                hash_byte(byte_data);
                bytes_sent++;
            end
            if (!byte_valid || !byte_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    byte_valid <= 1'b1;
                    byte_data  <= pending_bytes.pop_front();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        gbf_pkg::result_item_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, hash", '0, result_data.name_hash);
                else
                begin
                    want = expected_results.pop_front();
                    names_checked++;
                    if (result_data.may_exist !== want.may_exist)
                        report_mismatch("may_exist", 32'(want.may_exist),
                                        32'(result_data.may_exist));
                    else if (want.may_exist)
                        filter_hits++;
                    if (result_data.name_hash !== want.name_hash)
                        report_mismatch("name_hash", want.name_hash, result_data.name_hash);
                    if (result_data.word_index !== want.word_index)
                        report_mismatch("word_index", 32'(want.word_index),
                                        32'(result_data.word_index));
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic write_reg(input logic idx, input logic [gbf_pkg::WORDS_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == gbf_pkg::CFG_BLOOM_WORDS)
            words_in_use = value;
        else
            second_shift = value[gbf_pkg::SHIFT_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_name(input logic mode, input int unsigned len);
        gbf_pkg::byte_item_t item;
        for (int i = 0; i < len; i++)
        begin
            item.name_byte = draft[i];
            item.last_byte = (i == len - 1);
            item.mode      = item.last_byte ? mode : logic'($urandom_range(1));
            pending_bytes = {pending_bytes, item};
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || byte_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic fill_random(input int unsigned budget);
        int unsigned  sent;
        int unsigned  slot;
        int unsigned  len;
        logic         mode;
        sent = 0;
        while (sent < budget)
        begin
            if (known_count != 0 && $urandom_range(99) < 60)
            begin
                slot = $urandom_range(known_count - 1);
                len  = known_len[slot];
                for (int i = 0; i < len; i++)
                    draft[i] = known_names[slot][i];
                mode = logic'($urandom_range(1));
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(NAME_MAX, 6)
                                               : $urandom_range(5, 1);
                if (known_count < NAME_SLOTS)
                begin
                    slot = known_count;
                    known_count++;
                end
                else
                    slot = $urandom_range(NAME_SLOTS - 1);
                known_len[slot] = len;
                for (int i = 0; i < len; i++)
                begin
                    draft[i] = 8'($urandom_range(255));
                    known_names[slot][i] = draft[i];
                end
                mode = ($urandom_range(99) < 60) ? gbf_pkg::MODE_ADD : gbf_pkg::MODE_TEST;
            end
            queue_name(mode, len);
            sent += len;
        end
    endtask

    initial
    begin
        int unsigned                   phase_words [0:PHASES-1];
        int unsigned                   phase_shift [0:PHASES-1];
        logic [gbf_pkg::WORDS_W-1:0]   shift_value;
        phase_words = '{1, 2047, 3, 1024, 37, 0, 512, 7, 1024};
        phase_shift = '{0, 3, 6, 1, 5, 2, 7, 4, 0};

        sender_idle_pct = 20;
        recv_stall_pct  = 85;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty filter straight out of reset
        draft[0] = 8'h00;
        queue_name(gbf_pkg::MODE_ADD, 1);
        queue_name(gbf_pkg::MODE_TEST, 1);
        draft[0] = 8'hFF;
        queue_name(gbf_pkg::MODE_TEST, 1);
        drain();

        // full table, second index shifted by seven
        write_reg(gbf_pkg::CFG_BLOOM_WORDS, 11'd1024);
        write_reg(gbf_pkg::CFG_BLOOM_SHIFT, 11'd7);
        settings_used++;
        draft[0] = "a";
        draft[1] = "b";
        queue_name(gbf_pkg::MODE_ADD, 2);
        queue_name(gbf_pkg::MODE_TEST, 2);
        draft[0] = 8'hFF;
        queue_name(gbf_pkg::MODE_TEST, 1);
        draft[0] = 8'h00;
        queue_name(gbf_pkg::MODE_ADD, 1);
        queue_name(gbf_pkg::MODE_TEST, 1);
        for (int i = 0; i < 6; i++)
            draft[i] = i[0] ? 8'hFF : 8'h00;
        queue_name(gbf_pkg::MODE_ADD, 6);
        queue_name(gbf_pkg::MODE_TEST, 6);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p / 3)
                0:
                begin
                    sender_idle_pct = 20;
                    recv_stall_pct  = 85;
                end
                1:
                begin
                    sender_idle_pct = 85;
                    recv_stall_pct  = 20;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
            endcase
            shift_value = gbf_pkg::WORDS_W'(($urandom() << gbf_pkg::SHIFT_W)
                                            | phase_shift[p]);
            write_reg(gbf_pkg::CFG_BLOOM_WORDS, gbf_pkg::WORDS_W'(phase_words[p]));
            write_reg(gbf_pkg::CFG_BLOOM_SHIFT, shift_value);
            settings_used++;
            fill_random(PHASE_BYTES);
            drain();
        end

        $display("covered %0d byte transfers, %0d names checked with %0d filter hits",
                 bytes_sent, names_checked, filter_hits);
        $display("over %0d table size and shift settings, empty and oversized filters included",
                 settings_used);
        if (mismatch_count == 0)
            $display("gnu_hash_bloom_filter_test: PASS");
        else
            $display("gnu_hash_bloom_filter_test: FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("gnu_hash_bloom_filter_test: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/gbf_pkg.sv
hdl/gbf_front.sv
hdl/gbf_queue.sv
hdl/gbf_back.sv
hdl/gnu_hash_bloom_filter.sv
tb/gnu_hash_bloom_filter_test.sv
